// ----- src/owbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and reset values for the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd6;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd70;
  localparam logic [9:0] RESET_RECOV_DEF   = 10'd410;
  localparam logic [5:0] SHORT_LOW_DEF     = 6'd6;
  localparam logic [6:0] LONG_LOW_DEF      = 7'd60;
  localparam logic [6:0] READ_SAMPLE_DEF   = 7'd15;
  localparam logic [6:0] SLOT_DEF          = 7'd71;

  localparam int unsigned BITS_PER_TRANSFER_DEF = 8;

  // Bus operation, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_RESET = 4'b0010,
    PH_WRITE = 4'b0100,
    PH_READ  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_recov;
    logic [5:0] short_low;
    logic [6:0] long_low;
    logic [6:0] read_sample;
    logic [6:0] slot;
  } cfg_t;

  typedef struct packed {
    logic       rejected;
    logic [7:0] read_data;
    logic       presence;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage
`default_nettype wire

// ----- src/owbm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_core
// Bus timing state and the per-word step: command start, tick counting,
// slot sequencing, presence and read sampling.
// ----------------------------------------------------------------------------
module owbm_core
  import owbm_pkg::*;
#(
  parameter int unsigned BITS_PER_TRANSFER = BITS_PER_TRANSFER_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step_en,
  input  wire logic [1:0] command,
  input  wire logic [7:0] write_data,
  input  wire logic       line_level,
  input  wire cfg_t       cfg,
  output res_t            res
);

  localparam int unsigned CNT_W = $clog2(BITS_PER_TRANSFER + 1);

  phase_t                       phase, phase_next;
  logic [11:0]                  elapsed, elapsed_next, el_inc;
  logic [CNT_W-1:0]             bit_index, bit_index_next, bi_inc;
  logic [BITS_PER_TRANSFER-1:0] shift, shift_next, sh_cur, sh_nxt, sh_rd, sample_mask;
  logic [BITS_PER_TRANSFER+7:0] wd_ext, rd_ext;
  logic                         presence_flag, presence_flag_next;
  logic [7:0]                   last_read, last_read_next;
  logic                         line_driven, line_driven_next;
  logic                         done, rej;
  logic                         rd_hit;
  logic [10:0]                  pres_sum, pres_point;
  logic [11:0]                  done_point;
  logic [6:0]                   slot_len, sample_pt;

  // Low pulse length of the current slot
  function automatic logic [6:0] low_len(input logic is_read, input logic bit_val,
                                         input logic [5:0] short_us,
                                         input logic [6:0] long_us);
    if (is_read || bit_val) begin
      return {1'b0, short_us};
    end
    return long_us;
  endfunction

  assign el_inc      = elapsed + 12'd1;
  assign bi_inc      = bit_index + 1'b1;
  assign pres_sum    = {1'b0, cfg.reset_low} + {3'b000, cfg.presence_wait};
  assign pres_point  = (pres_sum == 11'd0) ? 11'd1 : pres_sum;
  assign done_point  = {1'b0, pres_point} + {2'b00, cfg.reset_recov};
  assign slot_len    = (cfg.slot == 7'd0) ? 7'd1 : cfg.slot;
  assign sample_pt   = (cfg.read_sample == 7'd0) ? 7'd1 : cfg.read_sample;
  assign wd_ext      = {{BITS_PER_TRANSFER{1'b0}}, write_data};
  assign sample_mask = BITS_PER_TRANSFER'(1) << bit_index;
  // Read bit captured on this tick, merged into the shift register
  assign rd_hit      = (phase == PH_READ) && (el_inc == {5'd0, sample_pt}) && line_level;
  assign sh_rd       = rd_hit ? (shift | sample_mask) : shift;
  assign sh_cur      = shift >> bit_index;
  assign sh_nxt      = shift >> bi_inc;
  assign rd_ext      = {8'h00, sh_rd};

  // One step of the bus sequencer
  always_comb begin
    phase_next         = phase;
    elapsed_next       = elapsed;
    bit_index_next     = bit_index;
    shift_next         = shift;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    line_driven_next   = line_driven;
    done               = 1'b0;
    rej                = 1'b0;
    if (command != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        elapsed_next   = 12'd0;
        bit_index_next = '0;
        case (command)
          CMD_RESET: begin
            phase_next         = PH_RESET;
            presence_flag_next = 1'b0;
            line_driven_next   = (cfg.reset_low != 10'd0);
          end
          CMD_WRITE: begin
            phase_next       = PH_WRITE;
            shift_next       = wd_ext[BITS_PER_TRANSFER-1:0];
            line_driven_next = (low_len(1'b0, write_data[0], cfg.short_low,
                                        cfg.long_low) != 7'd0);
          end
          default: begin
            phase_next       = PH_READ;
            shift_next       = '0;
            line_driven_next = (cfg.short_low != 6'd0);
          end
        endcase
      end
    end else if (phase == PH_RESET) begin
      elapsed_next = el_inc;
      if (el_inc == {1'b0, pres_point}) begin
        presence_flag_next = ~line_level;
      end
      if (el_inc >= done_point) begin
        phase_next       = PH_IDLE;
        elapsed_next     = 12'd0;
        done             = 1'b1;
        line_driven_next = 1'b0;
      end else begin
        line_driven_next = (el_inc < {2'b00, cfg.reset_low});
      end
    end else if (phase == PH_WRITE || phase == PH_READ) begin
      elapsed_next = el_inc;
      if (rd_hit) begin
        shift_next = sh_rd;
      end
      if (el_inc >= {5'd0, slot_len}) begin
        elapsed_next   = 12'd0;
        bit_index_next = bi_inc;
        if (bi_inc >= CNT_W'(BITS_PER_TRANSFER)) begin
          if (phase == PH_READ) begin
            last_read_next = rd_ext[7:0];
          end
          phase_next       = PH_IDLE;
          bit_index_next   = '0;
          done             = 1'b1;
          line_driven_next = 1'b0;
        end else begin
          line_driven_next = (low_len(phase == PH_READ, sh_nxt[0], cfg.short_low,
                                      cfg.long_low) != 7'd0);
        end
      end else begin
        line_driven_next = (el_inc < {5'd0, low_len(phase == PH_READ, sh_cur[0],
                                                    cfg.short_low, cfg.long_low)});
      end
    end
  end

  // Result of this step
  always_comb begin
    res.drive_low = line_driven_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_flag_next;
    res.read_data = last_read_next;
    res.rejected  = rej;
  end

  // Advance state once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      elapsed       <= 12'd0;
      bit_index     <= '0;
      shift         <= '0;
      presence_flag <= 1'b0;
      last_read     <= 8'h00;
      line_driven   <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      elapsed       <= elapsed_next;
      bit_index     <= bit_index_next;
      shift         <= shift_next;
      presence_flag <= presence_flag_next;
      last_read     <= last_read_next;
      line_driven   <= line_driven_next;
    end
  end

  // Completion always lands in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && done |=> phase == PH_IDLE)
    else $error("operation completed but sequencer not idle");

  // A rejected start leaves the operation untouched
  a_rej_hold: assert property (@(posedge clk) disable iff (rst)
    step_en && rej |=> $stable(phase) && $stable(elapsed) && $stable(bit_index))
    else $error("rejected start disturbed the running operation");

  // Line is released whenever the bus is idle
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !line_driven)
    else $error("line driven while idle");

  // Slot counter never passes the longest slot
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WRITE || phase == PH_READ) |-> elapsed < 12'd128)
    else $error("slot tick count out of range");

endmodule
`default_nettype wire

// ----- src/one_wire_bus_master.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master stepped by microsecond tick words: bus reset with
// presence detect, byte write and byte read, LSB first.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the input register, one step of the sequencer
//   and the result register before its result word appears.
// Throughput: one word per cycle unless the result stream stalls; the tick
//   step is one counter update and compare between the input and result registers.
// Reset: synchronous; registers return to their default timings, the bus is
//   idle and released, presence and read data clear. No clearing pass.
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned BITS_PER_TRANSFER = BITS_PER_TRANSFER_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Item stream in
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,  // write_data[7:0], line_level[8], zero
  input  wire logic [1:0]            s_tuser,  // command[1:0]
  // Result stream out
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [15:0]                m_tdata,  // drive_low[0], busy_res[1], done_res[2],
                                               // presence[3], read_data[11:4],
                                               // rejected[12], zero
  // Register write port
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  res_t       res;
  logic       in_valid;
  logic [1:0] in_cmd;
  logic [7:0] in_wdata;
  logic       in_line;
  logic       advance, step_en;

  assign advance   = !m_tvalid || m_tready;
  assign step_en   = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low     <= RESET_LOW_DEF;
      cfg.presence_wait <= PRESENCE_WAIT_DEF;
      cfg.reset_recov   <= RESET_RECOV_DEF;
      cfg.short_low     <= SHORT_LOW_DEF;
      cfg.long_low      <= LONG_LOW_DEF;
      cfg.read_sample   <= READ_SAMPLE_DEF;
      cfg.slot          <= SLOT_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low     <= cfg_data[9:0];
        REG_PRESENCE_WAIT: cfg.presence_wait <= cfg_data[7:0];
        REG_RESET_RECOV:   cfg.reset_recov   <= cfg_data[9:0];
        REG_SHORT_LOW:     cfg.short_low     <= cfg_data[5:0];
        REG_LONG_LOW:      cfg.long_low      <= cfg_data[6:0];
        REG_READ_SAMPLE:   cfg.read_sample   <= cfg_data[6:0];
        REG_SLOT:          cfg.slot          <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_wdata <= s_tdata[7:0];
      in_line  <= s_tdata[8];
    end
  end

  owbm_core #(
    .BITS_PER_TRANSFER (BITS_PER_TRANSFER)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .command    (in_cmd),
    .write_data (in_wdata),
    .line_level (in_line),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      m_tdata <= {3'b000, res};
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Drives tick and command words into the single-wire bus master and checks
// every status word against a cycle-free model of the bus sequencer. A short
// scripted run covers reset, write and read at minimum timings, rejection
// and the field extremes; random operations follow under zero and small
// random timings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
  import owbm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned RANDOM_WORDS = 1700;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] wdata;
    logic       line;
    logic [3:0] reps;
    logic       typed;
    res_t       want;
  } script_row_t;

  localparam res_t IDLE_WORD = '0;
  localparam res_t REJ_NO_PRES = '{rejected: 1'b1, read_data: 8'h00, presence: 1'b0,
                                   done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
  localparam res_t REJ_PRES = '{rejected: 1'b1, read_data: 8'h00, presence: 1'b1,
                                done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
  localparam cfg_t MIN_TIMING = '{10'd1, 8'd1, 10'd1, 6'd1, 7'd1, 7'd1, 7'd1};
  localparam cfg_t DEF_TIMING = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_RECOV_DEF,
                                  SHORT_LOW_DEF, LONG_LOW_DEF, READ_SAMPLE_DEF, SLOT_DEF};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;  // write_data[7:0], line_level[8], zero
  logic [1:0]            s_tuser = CMD_TICK;  // command[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;  // drive_low[0], busy_res[1], done_res[2], presence[3],
                                   // read_data[11:4], rejected[12], zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model state of the sequencer
  cfg_t        timing = DEF_TIMING;
  phase_t      op_phase = PH_IDLE;
  logic [11:0] ticks = '0;
  int unsigned bit_pos = 0;
  logic [7:0]  shift_reg = '0;
  logic        pres_flag = 1'b0;
  logic [7:0]  last_byte = '0;
  logic        pull_low = 1'b0;

  res_t        bus_status_q[$];
  int unsigned mismatches = 0;
  int unsigned status_words = 0;
  int unsigned src_calm = 0;
  int unsigned sink_calm = 0;
  int unsigned sink_hold = 0;
  res_t        want_word;
  res_t        got_word;

  one_wire_bus_master dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, and quiet stretches with none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 120);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Low pulse length of the current slot
  function automatic int unsigned slot_pulse();
    if (op_phase == PH_READ) return timing.short_low;
    return shift_reg[bit_pos[2:0]] ? timing.short_low : timing.long_low;
  endfunction

  // Advance the sequencer model by one word and return its status word
  function automatic res_t predict_status(logic [1:0] cmd, logic [7:0] wdata, logic line);
    res_t        w;
    logic        done;
    logic        rej;
    int unsigned point;
    int unsigned sample;
    int unsigned slen;
    done = 1'b0;
    rej = 1'b0;
    if (cmd != CMD_TICK) begin
      if (op_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        ticks = '0;
        bit_pos = 0;
        case (cmd)
          CMD_RESET: begin
            op_phase = PH_RESET;
            pres_flag = 1'b0;
            pull_low = timing.reset_low != 0;
          end
          CMD_WRITE: begin
            op_phase = PH_WRITE;
            shift_reg = wdata;
            pull_low = slot_pulse() != 0;
          end
          default: begin
            op_phase = PH_READ;
            shift_reg = '0;
            pull_low = slot_pulse() != 0;
          end
        endcase
      end
    end else if (op_phase == PH_RESET) begin
      point = timing.reset_low + timing.presence_wait;
      if (point == 0) point = 1;
      ticks = ticks + 12'd1;
      if (ticks == point) pres_flag = ~line;
      if (ticks >= point + timing.reset_recov) begin
        op_phase = PH_IDLE;
        ticks = '0;
        done = 1'b1;
        pull_low = 1'b0;
      end else begin
        pull_low = ticks < timing.reset_low;
      end
    end else if (op_phase == PH_WRITE || op_phase == PH_READ) begin
      sample = (timing.read_sample == 0) ? 1 : timing.read_sample;
      slen = (timing.slot == 0) ? 1 : timing.slot;
      ticks = ticks + 12'd1;
      if (op_phase == PH_READ && ticks == sample && line) shift_reg[bit_pos[2:0]] = 1'b1;
      if (ticks >= slen) begin
        ticks = '0;
        bit_pos++;
        if (bit_pos >= BITS_PER_TRANSFER_DEF) begin
          if (op_phase == PH_READ) last_byte = shift_reg;
          op_phase = PH_IDLE;
          bit_pos = 0;
          done = 1'b1;
          pull_low = 1'b0;
        end else begin
          pull_low = slot_pulse() != 0;
        end
      end else begin
        pull_low = ticks < slot_pulse();
      end
    end
    w.drive_low = pull_low;
    w.busy_res  = op_phase != PH_IDLE;
    w.done_res  = done;
    w.presence  = pres_flag;
    w.read_data = last_byte;
    w.rejected  = rej;
    return w;
  endfunction

  // Send one word after a random gap; queue the typed or predicted status
  task automatic put_word(input logic [1:0] cmd, input logic [7:0] wdata, input logic line,
                          input logic typed, input res_t want);
    int unsigned gap;
    res_t        pred;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, line, wdata};
    do @(posedge clk); while (!s_tready);
    pred = predict_status(cmd, wdata, line);
    bus_status_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until every status word is back
  task automatic settle(input int unsigned extra);
    s_tvalid <= 1'b0;
    while (bus_status_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write all timing registers, plus the unused index, with junk in spare bits
  task automatic load_timings(input cfg_t t);
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0]  idx;
    for (int i = 0; i <= REG_UNUSED; i++) begin
      idx = CFG_IDX_W'(i);
      data = CFG_DATA_W'($urandom);
      case (idx)
        REG_RESET_LOW:     data = t.reset_low;
        REG_PRESENCE_WAIT: data[7:0] = t.presence_wait;
        REG_RESET_RECOV:   data = t.reset_recov;
        REG_SHORT_LOW:     data[5:0] = t.short_low;
        REG_LONG_LOW:      data[6:0] = t.long_low;
        REG_READ_SAMPLE:   data[6:0] = t.read_sample;
        REG_SLOT:          data[6:0] = t.slot;
        default: ;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    timing = t;
  endtask

  // Result sink with random stalls
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= 1'b1;
      sink_hold <= pick_gap(sink_calm);
    end
  end

  // Compare each status word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      status_words++;
      if (bus_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status word %0d: none expected, got %h", status_words, m_tdata);
      end else begin
        want_word = bus_status_q.pop_front();
        got_word = res_t'(m_tdata[12:0]);
        if (got_word.drive_low != want_word.drive_low ||
            got_word.busy_res  != want_word.busy_res  ||
            got_word.done_res  != want_word.done_res  ||
            got_word.presence  != want_word.presence  ||
            got_word.read_data != want_word.read_data ||
            got_word.rejected  != want_word.rejected  ||
            m_tdata[15:13] != 3'b000) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("status word %0d: expected low=%b busy=%b done=%b pres=%b rd=%h rej=%b,",
                   status_words, want_word.drive_low, want_word.busy_res,
                   want_word.done_res, want_word.presence, want_word.read_data,
                   want_word.rejected);
            $display(" got low=%b busy=%b done=%b pres=%b rd=%h rej=%b pad=%b",
                     got_word.drive_low, got_word.busy_res, got_word.done_res,
                     got_word.presence, got_word.read_data, got_word.rejected,
                     m_tdata[15:13]);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t script [16];
    cfg_t        t;
    logic [1:0]  cmd;
    int unsigned counted;
    int unsigned stage;
    int unsigned nops;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Scripted run at minimum timings: every slot one tick, reset three ticks
    load_timings(MIN_TIMING);
    script = '{
      '{CMD_TICK,  8'hFF, 1'b1, 4'd1, 1'b1, IDLE_WORD},
      '{CMD_RESET, 8'h00, 1'b0, 4'd1, 1'b0, IDLE_WORD},
      '{CMD_WRITE, 8'hFF, 1'b1, 4'd1, 1'b1, REJ_NO_PRES},
      '{CMD_TICK,  8'h00, 1'b0, 4'd3, 1'b0, IDLE_WORD},
      '{CMD_WRITE, 8'h00, 1'b0, 4'd1, 1'b0, IDLE_WORD},
      '{CMD_READ,  8'h00, 1'b0, 4'd1, 1'b1, REJ_PRES},
      '{CMD_TICK,  8'h00, 1'b0, 4'd8, 1'b0, IDLE_WORD},
      '{CMD_WRITE, 8'hFF, 1'b1, 4'd1, 1'b0, IDLE_WORD},
      '{CMD_TICK,  8'h00, 1'b1, 4'd8, 1'b0, IDLE_WORD},
      '{CMD_READ,  8'h00, 1'b1, 4'd1, 1'b0, IDLE_WORD},
      '{CMD_RESET, 8'h00, 1'b1, 4'd1, 1'b1, REJ_PRES},
      '{CMD_TICK,  8'h00, 1'b1, 4'd8, 1'b0, IDLE_WORD},
      '{CMD_READ,  8'h00, 1'b0, 4'd1, 1'b0, IDLE_WORD},
      '{CMD_TICK,  8'h00, 1'b0, 4'd8, 1'b0, IDLE_WORD},
      '{CMD_RESET, 8'h00, 1'b1, 4'd4, 1'b0, IDLE_WORD},
      '{CMD_TICK,  8'h00, 1'b0, 4'd3, 1'b0, IDLE_WORD}
    };
    foreach (script[k])
      repeat (script[k].reps)
        put_word(script[k].cmd, script[k].wdata, script[k].line, script[k].typed,
                 script[k].want);

    // Random operations: zero timings once, then small ones
    counted = 0;
    stage = 0;
    while (counted < RANDOM_WORDS) begin
      settle(3);
      case (stage)
        0: t = '0;
        default: begin
          t.reset_low     = 10'($urandom_range(0, 24));
          t.presence_wait = 8'($urandom_range(0, 12));
          t.reset_recov   = 10'($urandom_range(0, 16));
          t.short_low     = 6'($urandom_range(0, 10));
          t.long_low      = 7'($urandom_range(0, 16));
          t.read_sample   = 7'($urandom_range(0, 16));
          t.slot          = 7'($urandom_range(0, 14));
        end
      endcase
      load_timings(t);
      nops = (stage == 0) ? 3 : $urandom_range(3, 8);
      for (int j = 0; j < nops; j++) begin
        // Ticks while idle do nothing; a few of them as noise
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            put_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
            counted++;
          end
        end
        if (stage == 0)
          cmd = (j == 0) ? CMD_RESET : (j == 1) ? CMD_WRITE : CMD_READ;
        else
          cmd = 2'($urandom_range(CMD_RESET, CMD_READ));
        put_word(cmd, 8'($urandom), 1'($urandom), 1'b0, '0);
        counted++;
        // Tick the operation through, with the odd start command while busy
        while (op_phase != PH_IDLE) begin
          if ($urandom_range(0, 99) < 4)
            cmd = 2'($urandom_range(CMD_RESET, CMD_READ));
          else
            cmd = CMD_TICK;
          put_word(cmd, 8'($urandom), 1'($urandom), 1'b0, '0);
          counted++;
        end
      end
      stage++;
    end

    settle(10);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
